// ===== rtl/core/fragment_reassembly_tracker_assert.svh =====
// Assertion macros used by the checker file of the fragment reassembly tracker.
`ifndef FRAGMENT_REASSEMBLY_TRACKER_ASSERT_SVH
`define FRAGMENT_REASSEMBLY_TRACKER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FRT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define FRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/frt_pkg.sv =====
// Package with the types and constants of the fragment reassembly tracker.
`default_nettype none

package frt_pkg;

  localparam int MAP_W      = 32;
  localparam int LIFE_W     = 24;
  localparam int STATUS_W   = 3;
  localparam int OUT_IDX_W  = 3;
  localparam int OUT_CNT_W  = 4;
  localparam int SRC_ADDR_W = 64;
  localparam int LEN_W      = 4;
  localparam int FRAG_ID_W  = 16;
  localparam int SEQ_W      = 5;

  localparam logic [MAP_W-1:0]  FULL_MAP       = 32'hFFFF_FFFF;
  localparam logic [MAP_W-1:0]  TOP_BIT        = 32'h8000_0000;
  localparam logic [LIFE_W-1:0] LIFETIME_RESET = 24'd10000;

  localparam logic REQ_FRAG = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_PENDING   = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_COMPLETE  = 3'd2,
    ST_DROPPED   = 3'd3,
    ST_TICK_DONE = 3'd4
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/core/fragment_reassembly_tracker.sv =====
// Fragment reassembly tracker: entry table with arrival maps and lifetime countdowns.
//
//   Channel  Direction  Handshake                Payload
//   in_      input      in_valid / in_ready      req_type, src_addr, src_addr_len,
//                                                frag_id, frag_seq, more_frags
//   out_     output     out_valid / out_ready    status, entry_index, expired_count
//   cfg_     input      cfg_wr_en (no wait)      cfg_wr_data (lifetime in ticks)
//
// One item is taken per cycle unless the output stalls; the lookup stage loads its result into the result register.
// The rate is set by the lookup stage, which compares the key against every entry
// register and updates the table at the same edge that loads the result register.
// Reset is synchronous, active low, and clears all entries; no clearing pass.
// A stalled output holds the lookup stage; the input register keeps one more item.
`default_nettype none

module fragment_reassembly_tracker #(
  parameter int TABLE_ENTRIES = 8,
  parameter int ADDR_BYTES    = 8
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire                                in_req_type,
  input  wire  [frt_pkg::SRC_ADDR_W-1:0]     in_src_addr,
  input  wire  [frt_pkg::LEN_W-1:0]          in_src_addr_len,
  input  wire  [frt_pkg::FRAG_ID_W-1:0]      in_frag_id,
  input  wire  [frt_pkg::SEQ_W-1:0]          in_frag_seq,
  input  wire                                in_more_frags,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic [frt_pkg::STATUS_W-1:0]       out_status,
  output logic [frt_pkg::OUT_IDX_W-1:0]      out_entry_index,
  output logic [frt_pkg::OUT_CNT_W-1:0]      out_expired_count,
  input  wire                                cfg_wr_en,
  input  wire  [frt_pkg::LIFE_W-1:0]         cfg_wr_data
);

  import frt_pkg::*;

  localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int ADDR_W = ADDR_BYTES * 8;

  // Configuration.
  logic [LIFE_W-1:0] lifetime_r;

  // Input register.
  logic              s_v_r;
  logic              s_req_r;
  logic [ADDR_W-1:0] s_addr_r;
  logic [LEN_W-1:0]  s_len_r;
  logic [FRAG_ID_W-1:0] s_id_r;
  logic [SEQ_W-1:0]  s_seq_r;
  logic              s_mf_r;

  // Entry table.
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [TABLE_ENTRIES-1:0] valid_nxt;
  logic [ADDR_W-1:0]        addr_r [TABLE_ENTRIES];
  logic [LEN_W-1:0]         len_r  [TABLE_ENTRIES];
  logic [FRAG_ID_W-1:0]     id_r   [TABLE_ENTRIES];
  logic [MAP_W-1:0]         map_r  [TABLE_ENTRIES];
  logic [LIFE_W-1:0]        time_r [TABLE_ENTRIES];

  // Result register.
  logic                 o_v_r;
  status_t              o_status_r;
  logic [OUT_IDX_W-1:0] o_idx_r;
  logic [OUT_CNT_W-1:0] o_cnt_r;

  // Lookup stage.
  logic                     out_adv;
  logic                     fire;
  logic [ADDR_W-1:0]        key_addr;
  logic [TABLE_ENTRIES-1:0] match_vec;
  logic [TABLE_ENTRIES-1:0] expire_vec;
  logic                     hit_found;
  logic [IDX_W-1:0]         hit_idx;
  logic                     free_found;
  logic [IDX_W-1:0]         free_idx;
  logic [IDX_W-1:0]         sel_idx;
  logic                     drop;
  logic [MAP_W-1:0]         cur_map;
  logic [MAP_W-1:0]         seq_map;
  logic [MAP_W-1:0]         new_map;
  logic                     dup;
  logic                     complete;
  logic [CNT_W-1:0]         exp_cnt;
  logic [31:0]              idx_ext;
  logic [31:0]              cnt_ext;
  status_t                  status_nxt;

  assign out_adv  = !o_v_r || out_ready;
  assign fire     = s_v_r && out_adv;
  assign in_ready = !s_v_r || out_adv;

  always_comb begin
    for (int b = 0; b < ADDR_BYTES; b++) begin
      key_addr[b*8 +: 8] = (4'(b) < s_len_r) ? s_addr_r[b*8 +: 8] : 8'h00;
    end
  end

  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      match_vec[i]  = valid_r[i] && (len_r[i] == s_len_r) && (addr_r[i] == key_addr) &&
                      (id_r[i] == s_id_r);
      // A countdown of one or zero runs out on this tick.
      expire_vec[i] = valid_r[i] && (time_r[i][LIFE_W-1:1] == '0);
    end
  end

  // Lowest matching entry and lowest free entry.
  always_comb begin
    hit_found  = 1'b0;
    hit_idx    = '0;
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        hit_found = 1'b1;
        hit_idx   = IDX_W'(i);
      end
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  always_comb begin
    exp_cnt = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      exp_cnt = exp_cnt + CNT_W'(expire_vec[i]);
    end
  end

  always_comb begin
    sel_idx  = hit_found ? hit_idx : free_idx;
    drop     = !hit_found && !free_found;
    cur_map  = hit_found ? map_r[hit_idx] : '0;
    // A last fragment marks its own bit and every later one.
    seq_map  = s_mf_r ? (TOP_BIT >> s_seq_r) : (FULL_MAP >> s_seq_r);
    new_map  = cur_map | seq_map;
    dup      = (cur_map & seq_map) != '0;
    complete = !dup && (new_map == FULL_MAP);
    idx_ext  = 32'(sel_idx);
    cnt_ext  = 32'(exp_cnt);
  end

  always_comb begin
    valid_nxt = valid_r;
    if (s_req_r == REQ_TICK) begin
      valid_nxt  = valid_r & ~expire_vec;
      status_nxt = ST_TICK_DONE;
    end else if (drop) begin
      status_nxt = ST_DROPPED;
    end else begin
      valid_nxt[sel_idx] = !complete;
      if (dup) begin
        status_nxt = ST_DUPLICATE;
      end else if (complete) begin
        status_nxt = ST_COMPLETE;
      end else begin
        status_nxt = ST_PENDING;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lifetime_r <= LIFETIME_RESET;
      s_v_r      <= 1'b0;
      valid_r    <= '0;
      o_v_r      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        lifetime_r <= cfg_wr_data;
      end
      if (in_ready) begin
        s_v_r <= in_valid;
      end
      if (fire) begin
        valid_r <= valid_nxt;
        o_v_r   <= 1'b1;
      end else if (out_ready) begin
        o_v_r <= 1'b0;
      end
    end
  end

  // Input payload.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_req_r  <= in_req_type;
      s_addr_r <= in_src_addr[ADDR_W-1:0];
      s_len_r  <= in_src_addr_len;
      s_id_r   <= in_frag_id;
      s_seq_r  <= in_frag_seq;
      s_mf_r   <= in_more_frags;
    end
  end

  // Table payload.
  always_ff @(posedge clk) begin
    if (fire) begin
      if (s_req_r == REQ_TICK) begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (valid_r[i] && !expire_vec[i]) begin
            time_r[i] <= time_r[i] - LIFE_W'(1);
          end
        end
      end else if (!drop) begin
        time_r[sel_idx] <= lifetime_r;
        if (!hit_found) begin
          addr_r[sel_idx] <= key_addr;
          len_r[sel_idx]  <= s_len_r;
          id_r[sel_idx]   <= s_id_r;
        end
        if (!dup) begin
          map_r[sel_idx] <= new_map;
        end
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (fire) begin
      o_status_r <= status_nxt;
      if (s_req_r == REQ_TICK) begin
        o_idx_r <= '0;
        o_cnt_r <= cnt_ext[OUT_CNT_W-1:0];
      end else begin
        o_idx_r <= drop ? '0 : idx_ext[OUT_IDX_W-1:0];
        o_cnt_r <= '0;
      end
    end
  end

  assign out_valid         = o_v_r;
  assign out_status        = o_status_r;
  assign out_entry_index   = o_idx_r;
  assign out_expired_count = o_cnt_r;

endmodule

`default_nettype wire

// ===== rtl/core/frt_checker.sv =====
// Port-level checker for the fragment reassembly tracker, with its bind.
`default_nettype none

module frt_checker (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              out_valid,
  input wire                              out_ready,
  input wire [frt_pkg::STATUS_W-1:0]      out_status,
  input wire [frt_pkg::OUT_IDX_W-1:0]     out_entry_index,
  input wire [frt_pkg::OUT_CNT_W-1:0]     out_expired_count
);

  import frt_pkg::*;

`include "fragment_reassembly_tracker_assert.svh"

  // A tick names no entry.
  `FRT_ASSERT_NOW(a_tick_no_index, clk, rst_n,
    out_valid && (out_status == ST_TICK_DONE), out_entry_index == '0,
    "tick result carries an entry index")

  // Only a tick frees entries by timeout.
  `FRT_ASSERT_NOW(a_count_only_on_tick, clk, rst_n,
    out_valid && (out_status != ST_TICK_DONE), out_expired_count == '0,
    "fragment result carries an expired count")

  // A dropped fragment uses no entry.
  `FRT_ASSERT_NOW(a_drop_no_index, clk, rst_n,
    out_valid && (out_status == ST_DROPPED), out_entry_index == '0,
    "dropped fragment reports an entry index")

  // A stalled result holds.
  `FRT_ASSERT_NEXT(a_out_hold, clk, rst_n,
    out_valid && !out_ready,
    out_valid && $stable(out_status) && $stable(out_entry_index) &&
    $stable(out_expired_count),
    "stalled result changed")

endmodule

bind fragment_reassembly_tracker frt_checker u_frt_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_status        (out_status),
  .out_entry_index   (out_entry_index),
  .out_expired_count (out_expired_count)
);

`default_nettype wire
